### rtl/core/qgcw_pkg.sv
// Package for the quad grid connectivity writer.
// Holds field widths, register indexes, table codes, sequence codes and the
// command and status types shared by the controller and the datapath.
package qgcw_pkg;

    localparam int PA_W        = 9;
    localparam int NE_W        = 16;
    localparam int NF_W        = 17;
    localparam int CELL_W      = 8;
    localparam int TABLE_W     = 2;
    localparam int ADDR_W      = 19;
    localparam int VALUE_W     = 17;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 17;
    localparam int PROD_W      = CELL_W + PA_W;

    localparam int MAX_SIDE_POINTS_DEFAULT = 256;

    localparam logic [CFG_INDEX_W-1:0] REG_POINTS_ACROSS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_POINTS_UP     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ELEMENT_COUNT = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_FACE_COUNT    = 2'd3;

    localparam logic [PA_W-1:0] POINTS_ACROSS_RESET = 9'd2;
    localparam logic [PA_W-1:0] POINTS_UP_RESET     = 9'd2;
    localparam logic [NE_W-1:0] ELEMENT_COUNT_RESET = 16'd1;
    localparam logic [NF_W-1:0] FACE_COUNT_RESET    = 17'd5;

    localparam logic [TABLE_W-1:0] TABLE_CORNERS     = 2'd0;
    localparam logic [TABLE_W-1:0] TABLE_FACE_POINTS = 2'd1;
    localparam logic [TABLE_W-1:0] TABLE_FACE_ELEMS  = 2'd2;

    localparam logic [ADDR_W-1:0] ORIENT_VERTICAL   = 19'd0;
    localparam logic [ADDR_W-1:0] ORIENT_HORIZONTAL = 19'd1;
    localparam logic [ADDR_W-1:0] NO_ELEMENT        = '1;

    localparam int GROUP_W = 3;
    localparam logic [GROUP_W-1:0] GRP_CORNER = 3'd0;
    localparam logic [GROUP_W-1:0] GRP_LEFT   = 3'd1;
    localparam logic [GROUP_W-1:0] GRP_BOTTOM = 3'd2;
    localparam logic [GROUP_W-1:0] GRP_RIGHT  = 3'd3;
    localparam logic [GROUP_W-1:0] GRP_TOP    = 3'd4;

    localparam int SLOT_W = 3;
    localparam logic [SLOT_W-1:0] CORNER_BL   = 3'd0;
    localparam logic [SLOT_W-1:0] CORNER_BR   = 3'd1;
    localparam logic [SLOT_W-1:0] CORNER_TR   = 3'd2;
    localparam logic [SLOT_W-1:0] CORNER_TL   = 3'd3;
    localparam logic [SLOT_W-1:0] SLOT_PT0    = 3'd0;
    localparam logic [SLOT_W-1:0] SLOT_PT1    = 3'd1;
    localparam logic [SLOT_W-1:0] SLOT_EL0    = 3'd2;
    localparam logic [SLOT_W-1:0] SLOT_EL1    = 3'd3;
    localparam logic [SLOT_W-1:0] SLOT_ORIENT = 3'd4;

    typedef struct packed {
        logic                capture;
        logic                calc_prod;
        logic                calc_base;
        logic                calc_deriv;
        logic                emit;
        logic [GROUP_W-1:0]  group;
        logic [SLOT_W-1:0]   slot;
        logic                last;
    } qgcw_cmd_t;

    typedef struct packed {
        logic outside;
        logic right_face;
        logic top_face;
    } qgcw_status_t;

endpackage

### rtl/core/qgcw_ctrl.sv
// Controller of the quad grid connectivity writer.
// Sequences setup and the write sequence of one cell; depends on qgcw_pkg.
module qgcw_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    output logic                  out_valid,
    input  logic                  out_stall,
    output qgcw_pkg::qgcw_cmd_t   cmd,
    input  qgcw_pkg::qgcw_status_t status
);
    import qgcw_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PROD  = 3'd1;
    localparam logic [2:0] S_BASE  = 3'd2;
    localparam logic [2:0] S_DERIV = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic [GROUP_W-1:0] group_reg, group_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_free;
    logic               seq_end;
    logic               done_after;
    logic [GROUP_W-1:0] group_after;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        seq_end     = (slot_reg == SLOT_ORIENT);
        done_after  = 1'b0;
        group_after = GRP_TOP;
        unique case (group_reg)
            GRP_CORNER:
            begin
                seq_end     = (slot_reg == CORNER_TL);
                group_after = GRP_LEFT;
            end
            GRP_LEFT:
            begin
                group_after = GRP_BOTTOM;
            end
            GRP_BOTTOM:
            begin
                group_after = status.right_face ? GRP_RIGHT : GRP_TOP;
                done_after  = !status.right_face && !status.top_face;
            end
            GRP_RIGHT:
            begin
                group_after = GRP_TOP;
                done_after  = !status.top_face;
            end
            default:
            begin
                done_after = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        group_next      = group_reg;
        slot_next       = slot_reg;
        cmd             = '0;
        cmd.group       = group_reg;
        cmd.slot        = slot_reg;
        cmd.last        = seq_end && done_after;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_PROD;
                end
            end
            S_PROD:
            begin
                cmd.calc_prod = 1'b1;
                state_next    = S_BASE;
            end
            S_BASE:
            begin
                if (status.outside)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.calc_base = 1'b1;
                    state_next    = S_DERIV;
                end
            end
            S_DERIV:
            begin
                cmd.calc_deriv = 1'b1;
                group_next     = GRP_CORNER;
                slot_next      = CORNER_BL;
                state_next     = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    cmd.emit = 1'b1;
                    if (seq_end && done_after)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (seq_end)
                    begin
                        group_next = group_after;
                        slot_next  = SLOT_PT0;
                    end
                    else
                    begin
                        slot_next = slot_reg + SLOT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            group_reg     <= GRP_CORNER;
            slot_reg      <= CORNER_BL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            group_reg     <= group_next;
            slot_reg      <= slot_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### rtl/core/qgcw_dpath.sv
// Datapath of the quad grid connectivity writer.
// Holds the configuration registers, the cell's index arithmetic and the
// output register; depends on qgcw_pkg.
module qgcw_dpath
#(
    parameter int MAX_SIDE_POINTS = qgcw_pkg::MAX_SIDE_POINTS_DEFAULT
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [qgcw_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [qgcw_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic [qgcw_pkg::CELL_W-1:0]        cell_i,
    input  logic [qgcw_pkg::CELL_W-1:0]        cell_j,
    input  qgcw_pkg::qgcw_cmd_t                cmd,
    output qgcw_pkg::qgcw_status_t             status,
    output logic [qgcw_pkg::TABLE_W-1:0]       target_table,
    output logic [qgcw_pkg::ADDR_W-1:0]        write_address,
    output logic signed [qgcw_pkg::VALUE_W-1:0] write_value,
    output logic                               last_write
);
    import qgcw_pkg::*;

    localparam int PA_MAX = (1 << PA_W) - 1;
    localparam logic [PA_W-1:0] SIDE_LIMIT =
        PA_W'(MAX_SIDE_POINTS > PA_MAX ? PA_MAX : MAX_SIDE_POINTS);

    logic [PA_W-1:0]    points_across_reg;
    logic [PA_W-1:0]    points_up_reg;
    logic [NE_W-1:0]    element_count_reg;
    logic [NF_W-1:0]    face_count_reg;

    logic [CELL_W-1:0]  i_reg, j_reg;
    logic [PROD_W-1:0]  prod_el_reg, prod_el_next;
    logic [PROD_W-1:0]  prod_pt_reg, prod_pt_next;
    logic               outside_reg, outside_next;
    logic               right_reg, right_next;
    logic               top_reg, top_next;
    logic [ADDR_W-1:0]  el_reg, el_next;
    logic [ADDR_W-1:0]  p00_reg, p00_next;
    logic [ADDR_W-1:0]  p10_reg, p10_next;
    logic [ADDR_W-1:0]  p01_reg, p01_next;
    logic [ADDR_W-1:0]  p11_reg, p11_next;
    logic [ADDR_W-1:0]  el_left_reg, el_left_next;
    logic [ADDR_W-1:0]  el_below_reg, el_below_next;
    logic [ADDR_W-1:0]  face_l_reg, face_l_next;
    logic [ADDR_W-1:0]  face_b_reg, face_b_next;
    logic [ADDR_W-1:0]  face_r_reg, face_r_next;
    logic [ADDR_W-1:0]  face_t_reg, face_t_next;
    logic [ADDR_W-1:0]  ne_reg, ne_next;
    logic [ADDR_W-1:0]  ne2_reg, ne2_next;
    logic [ADDR_W-1:0]  ne3_reg, ne3_next;
    logic [ADDR_W-1:0]  nf_reg, nf_next;
    logic [ADDR_W-1:0]  nf2_reg, nf2_next;

    logic [TABLE_W-1:0] table_reg, table_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic               last_reg;

    logic [PA_W-1:0]    nx, ny, cols;
    logic [ADDR_W-1:0]  sel_base, sel_off, sel_value;
    logic [ADDR_W-1:0]  face_base, fp0, fp1, fe0, fe1, forient;

    assign nx   = (points_across_reg > SIDE_LIMIT) ? SIDE_LIMIT : points_across_reg;
    assign ny   = (points_up_reg > SIDE_LIMIT) ? SIDE_LIMIT : points_up_reg;
    assign cols = nx - PA_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            points_across_reg <= POINTS_ACROSS_RESET;
            points_up_reg     <= POINTS_UP_RESET;
            element_count_reg <= ELEMENT_COUNT_RESET;
            face_count_reg    <= FACE_COUNT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_POINTS_ACROSS: points_across_reg <= cfg_data[PA_W-1:0];
                REG_POINTS_UP:     points_up_reg     <= cfg_data[PA_W-1:0];
                REG_ELEMENT_COUNT: element_count_reg <= cfg_data[NE_W-1:0];
                REG_FACE_COUNT:    face_count_reg    <= cfg_data[NF_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        prod_el_next = PROD_W'(j_reg) * PROD_W'(cols);
        prod_pt_next = PROD_W'(j_reg) * PROD_W'(nx);
        outside_next = ((PA_W'(i_reg) + PA_W'(1)) >= nx) ||
                       ((PA_W'(j_reg) + PA_W'(1)) >= ny);
        right_next   = (PA_W'(i_reg) == (nx - PA_W'(2)));
        top_next     = (PA_W'(j_reg) == (ny - PA_W'(2)));

        el_next  = ADDR_W'(prod_el_reg) + ADDR_W'(i_reg);
        p00_next = ADDR_W'(prod_pt_reg) + ADDR_W'(i_reg);

        p10_next      = p00_reg + ADDR_W'(1);
        p01_next      = p00_reg + ADDR_W'(nx);
        p11_next      = p01_next + ADDR_W'(1);
        el_left_next  = el_reg - ADDR_W'(1);
        el_below_next = el_reg - ADDR_W'(cols);
        face_l_next   = {el_reg[ADDR_W-2:0], 1'b0};
        face_b_next   = {el_reg[ADDR_W-2:0], 1'b1};
        ne_next       = ADDR_W'(element_count_reg);
        ne2_next      = {ne_next[ADDR_W-2:0], 1'b0};
        ne3_next      = ne2_next + ne_next;
        nf_next       = ADDR_W'(face_count_reg);
        nf2_next      = {nf_next[ADDR_W-2:0], 1'b0};
        face_r_next   = ne2_next + ADDR_W'(1) + ADDR_W'(j_reg);
        face_t_next   = ne2_next + ADDR_W'(ny) + ADDR_W'(i_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            i_reg <= cell_i;
            j_reg <= cell_j;
        end
        if (cmd.calc_prod)
        begin
            prod_el_reg <= prod_el_next;
            prod_pt_reg <= prod_pt_next;
            outside_reg <= outside_next;
            right_reg   <= right_next;
            top_reg     <= top_next;
        end
        if (cmd.calc_base)
        begin
            el_reg  <= el_next;
            p00_reg <= p00_next;
        end
        if (cmd.calc_deriv)
        begin
            p10_reg      <= p10_next;
            p01_reg      <= p01_next;
            p11_reg      <= p11_next;
            el_left_reg  <= el_left_next;
            el_below_reg <= el_below_next;
            face_l_reg   <= face_l_next;
            face_b_reg   <= face_b_next;
            face_r_reg   <= face_r_next;
            face_t_reg   <= face_t_next;
            ne_reg       <= ne_next;
            ne2_reg      <= ne2_next;
            ne3_reg      <= ne3_next;
            nf_reg       <= nf_next;
            nf2_reg      <= nf2_next;
        end
        if (cmd.emit)
        begin
            table_reg <= table_next;
            addr_reg  <= addr_next;
            value_reg <= value_next;
            last_reg  <= cmd.last;
        end
    end

    assign status.outside    = outside_reg;
    assign status.right_face = right_reg;
    assign status.top_face   = top_reg;

    always_comb
    begin
        face_base = face_t_reg;
        fp0       = p01_reg;
        fp1       = p11_reg;
        fe0       = el_reg;
        fe1       = NO_ELEMENT;
        forient   = ORIENT_HORIZONTAL;
        unique case (cmd.group)
            GRP_LEFT:
            begin
                face_base = face_l_reg;
                fp0       = p00_reg;
                fp1       = p01_reg;
                fe0       = (i_reg == '0) ? NO_ELEMENT : el_left_reg;
                fe1       = el_reg;
                forient   = ORIENT_VERTICAL;
            end
            GRP_BOTTOM:
            begin
                face_base = face_b_reg;
                fp0       = p00_reg;
                fp1       = p10_reg;
                fe0       = el_reg;
                fe1       = (j_reg == '0) ? NO_ELEMENT : el_below_reg;
                forient   = ORIENT_HORIZONTAL;
            end
            GRP_RIGHT:
            begin
                face_base = face_r_reg;
                fp0       = p10_reg;
                fp1       = p11_reg;
                fe0       = NO_ELEMENT;
                fe1       = el_reg;
                forient   = ORIENT_VERTICAL;
            end
            default:
            begin
                face_base = face_t_reg;
            end
        endcase
    end

    always_comb
    begin
        table_next = TABLE_FACE_ELEMS;
        sel_base   = face_base;
        sel_off    = '0;
        sel_value  = '0;
        if (cmd.group == GRP_CORNER)
        begin
            table_next = TABLE_CORNERS;
            sel_base   = el_reg;
            unique case (cmd.slot)
                CORNER_BL:
                begin
                    sel_value = p00_reg;
                end
                CORNER_BR:
                begin
                    sel_off   = ne_reg;
                    sel_value = p10_reg;
                end
                CORNER_TR:
                begin
                    sel_off   = ne2_reg;
                    sel_value = p11_reg;
                end
                CORNER_TL:
                begin
                    sel_off   = ne3_reg;
                    sel_value = p01_reg;
                end
                default:
                begin
                    sel_value = '0;
                end
            endcase
        end
        else
        begin
            unique case (cmd.slot)
                SLOT_PT0:
                begin
                    table_next = TABLE_FACE_POINTS;
                    sel_value  = fp0;
                end
                SLOT_PT1:
                begin
                    table_next = TABLE_FACE_POINTS;
                    sel_off    = nf_reg;
                    sel_value  = fp1;
                end
                SLOT_EL0:
                begin
                    sel_value = fe0;
                end
                SLOT_EL1:
                begin
                    sel_off   = nf_reg;
                    sel_value = fe1;
                end
                SLOT_ORIENT:
                begin
                    sel_off   = nf2_reg;
                    sel_value = forient;
                end
                default:
                begin
                    sel_value = '0;
                end
            endcase
        end
        addr_next  = sel_base + sel_off;
        value_next = sel_value[VALUE_W-1:0];
    end

    assign target_table  = table_reg;
    assign write_address = addr_reg;
    assign write_value   = value_reg;
    assign last_write    = last_reg;

endmodule

### rtl/core/quad_grid_connectivity_writer.sv
// Top level of the quad grid connectivity writer.
// Joins the controller qgcw_ctrl and the datapath qgcw_dpath; depends on qgcw_pkg.
//
// For each requested cell (cell_i, cell_j) the block emits the table writes that
// build its unstructured connectivity: four corner points, then the left and
// bottom faces, then a right face on the last column and a top face on the last
// row, one write per cycle through an output register while out_stall does not
// hold it, with last_write marking the final write of the cell: 14, 19 or 24
// writes. A request is taken in an idle cycle and is followed by setup, in
// which the row products are formed through two small multipliers, then the
// element and point indexes, then the derived offsets are registered, and then
// by the writes. A cell outside the grid emits nothing and returns to idle once
// the products are formed. The block works on one cell at a time; the user
// must write configuration through cfg_write, cfg_index and cfg_data only while
// the block is idle; the block itself does not enforce this.
module quad_grid_connectivity_writer
#(
    parameter int MAX_SIDE_POINTS = qgcw_pkg::MAX_SIDE_POINTS_DEFAULT
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [qgcw_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [qgcw_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [qgcw_pkg::CELL_W-1:0]         cell_i,
    input  logic [qgcw_pkg::CELL_W-1:0]         cell_j,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [qgcw_pkg::TABLE_W-1:0]        target_table,
    output logic [qgcw_pkg::ADDR_W-1:0]         write_address,
    output logic signed [qgcw_pkg::VALUE_W-1:0] write_value,
    output logic                                last_write
);
    import qgcw_pkg::*;

    qgcw_cmd_t    cmd;
    qgcw_status_t status;

    qgcw_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    qgcw_dpath
    #(
        .MAX_SIDE_POINTS (MAX_SIDE_POINTS)
    )
    u_dpath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cell_i        (cell_i),
        .cell_j        (cell_j),
        .cmd           (cmd),
        .status        (status),
        .target_table  (target_table),
        .write_address (write_address),
        .write_value   (write_value),
        .last_write    (last_write)
    );

endmodule
